FILE: rtl/core/ldim_pkg.sv
// Shared types and constants for the LED fade dimmer.
package ldim_pkg;

  localparam int LEVEL_W  = 8;
  localparam int CMD_W    = 4;
  localparam int NUM_BANDS = 6;
  localparam int BAND_W   = 3;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL       = 8'd255;
  localparam logic [LEVEL_W-1:0] TOGGLE_THRESHOLD = 8'd250;
  localparam int                 BAND_SIZE        = 50;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SET_TARGET = 4'd1;
  localparam logic [CMD_W-1:0] CMD_FULL_ON    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_TOGGLE_MAX = 4'd3;
  localparam logic [CMD_W-1:0] CMD_TRIGGER    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SET_MAX    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_OFF        = 4'd6;
  localparam logic [CMD_W-1:0] CMD_STATE_OFF  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_STATE_ON   = 4'd8;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_MEDIUM = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BAND0  = 3'd2;

  // Register reset values
  localparam logic [LEVEL_W-1:0] MEDIUM_RST = 8'd128;
  localparam logic [LEVEL_W-1:0] NIGHT_RST  = 8'd0;
  localparam logic [NUM_BANDS-1:0][LEVEL_W-1:0] BAND_RST =
    {8'd5, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};

  typedef struct packed {
    logic [LEVEL_W-1:0]                medium_level;
    logic [LEVEL_W-1:0]                night_level;
    logic [NUM_BANDS-1:0][LEVEL_W-1:0] step_band;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_level;
    logic               ramping;
    logic               lit;
    logic               on_state;
  } result_t;

endpackage

FILE: rtl/core/ldim_if.sv
// Valid/ready channel interfaces for commands and results.
interface ldim_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface ldim_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_level;
  logic       ramping;
  logic       lit;
  logic       on_state;

  modport source (output valid, output pwm_level, output ramping, output lit,
                  output on_state, input ready);
  modport sink   (input valid, input pwm_level, input ramping, input lit,
                  input on_state, output ready);
endinterface

FILE: rtl/core/ldim_regs.sv
// APB configuration registers for the dimmer.
module ldim_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ldim_pkg::ADDR_W-1:0]  paddr,
  input  logic [ldim_pkg::DATA_W-1:0]  pwdata,
  output logic [ldim_pkg::DATA_W-1:0]  prdata,
  output ldim_pkg::cfg_t               cfg
);
  import ldim_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic [REG_IDX_W-1:0] band_idx;
  logic                 wr;
  logic [LEVEL_W-1:0]   rd_val;

  assign idx      = paddr[ADDR_W-1:2];
  assign band_idx = idx - REG_BAND0;
  assign wr       = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.medium_level <= MEDIUM_RST;
      cfg.night_level  <= NIGHT_RST;
      cfg.step_band    <= BAND_RST;
    end else if (wr) begin
      case (idx)
        REG_MEDIUM: cfg.medium_level <= pwdata[LEVEL_W-1:0];
        REG_NIGHT:  cfg.night_level  <= pwdata[LEVEL_W-1:0];
        default:    cfg.step_band[band_idx] <= pwdata[LEVEL_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MEDIUM: rd_val = cfg.medium_level;
      REG_NIGHT:  rd_val = cfg.night_level;
      default:    rd_val = cfg.step_band[band_idx];
    endcase
  end

  assign prdata = {{(DATA_W-LEVEL_W){1'b0}}, rd_val};

endmodule

FILE: rtl/core/ldim_ramp.sv
// One ramp step of the PWM level toward the target.
module ldim_ramp (
  input  logic [ldim_pkg::LEVEL_W-1:0]                          level,
  input  logic [ldim_pkg::LEVEL_W-1:0]                          target,
  input  logic [ldim_pkg::NUM_BANDS-1:0][ldim_pkg::LEVEL_W-1:0] step_band,
  output logic [ldim_pkg::LEVEL_W-1:0]                          level_next
);
  import ldim_pkg::*;

  logic [BAND_W-1:0]  band;
  logic [LEVEL_W-1:0] step;
  logic [LEVEL_W-1:0] dt;
  logic [LEVEL_W:0]   up_sum;
  logic [LEVEL_W-1:0] dn_diff;

  // Band is level/50, capped at the last band.
  always_comb begin
    band = '0;
    for (int k = 1; k < NUM_BANDS; k++) begin
      if (level >= LEVEL_W'(k * BAND_SIZE)) band = BAND_W'(k);
    end
  end

  assign step    = step_band[band];
  assign dt      = (step > level) ? LEVEL_W'(1) : step;
  assign up_sum  = {1'b0, level} + {1'b0, dt};
  assign dn_diff = level - dt;

  always_comb begin
    if (level == target) begin
      level_next = level;
    end else if (level < target) begin
      level_next = (up_sum > {1'b0, target}) ? target : up_sum[LEVEL_W-1:0];
    end else begin
      level_next = (dn_diff < target) ? target : dn_diff;
    end
  end

endmodule

FILE: rtl/core/ldim_core.sv
// Dimmer state: command decode, state update and result fields.
module ldim_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [ldim_pkg::CMD_W-1:0]   command,
  input  logic [ldim_pkg::LEVEL_W-1:0] value,
  input  ldim_pkg::cfg_t               cfg,
  output ldim_pkg::result_t            result
);
  import ldim_pkg::*;

  logic [LEVEL_W-1:0] current_level, current_level_next;
  logic [LEVEL_W-1:0] target_level, target_level_next;
  logic [LEVEL_W-1:0] max_brightness, max_brightness_next;
  logic               switched_on, switched_on_next;
  logic [LEVEL_W-1:0] ramp_level;

  ldim_ramp u_ramp (
    .level      (current_level),
    .target     (target_level),
    .step_band  (cfg.step_band),
    .level_next (ramp_level)
  );

  always_comb begin
    current_level_next  = current_level;
    target_level_next   = target_level;
    max_brightness_next = max_brightness;
    switched_on_next    = switched_on;
    case (command)
      CMD_TICK:       current_level_next = ramp_level;
      CMD_SET_TARGET: target_level_next  = value;
      CMD_FULL_ON: begin
        max_brightness_next = FULL_LEVEL;
        target_level_next   = FULL_LEVEL;
        switched_on_next    = 1'b1;
      end
      CMD_TOGGLE_MAX: begin
        target_level_next = (target_level > TOGGLE_THRESHOLD) ? cfg.medium_level
                                                              : FULL_LEVEL;
      end
      CMD_TRIGGER: begin
        target_level_next = switched_on ? '0 : cfg.medium_level;
        switched_on_next  = !switched_on;
      end
      CMD_SET_MAX: begin
        max_brightness_next = value;
        if (switched_on) target_level_next = value;
      end
      CMD_OFF: begin
        switched_on_next    = 1'b0;
        max_brightness_next = cfg.medium_level;
        target_level_next   = '0;
      end
      CMD_STATE_OFF: begin
        switched_on_next  = 1'b0;
        target_level_next = '0;
      end
      CMD_STATE_ON: begin
        switched_on_next  = 1'b1;
        target_level_next = max_brightness;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level  <= '0;
      target_level   <= '0;
      max_brightness <= FULL_LEVEL;
      switched_on    <= 1'b0;
    end else if (advance) begin
      current_level  <= current_level_next;
      target_level   <= target_level_next;
      max_brightness <= max_brightness_next;
      switched_on    <= switched_on_next;
    end
  end

  assign result.pwm_level = current_level_next;
  assign result.ramping   = (current_level != target_level);
  assign result.lit       = switched_on_next && (target_level_next > cfg.night_level);
  assign result.on_state  = switched_on_next;

endmodule

FILE: rtl/core/led_fade_dimmer.sv
// Top level of the LED fade dimmer: command stage, state core, result register.
//
//  channel | role    | transfer when        | payload
//  --------+---------+----------------------+-----------------------------------
//  cmd     | sink    | cmd.valid & ready    | command[3:0], value[7:0]
//  res     | source  | res.valid & ready    | pwm_level[7:0], ramping, lit, on_state
//  apb     | target  | psel&penable&pwrite  | paddr[4:2] selects one of 8 registers
//
// One command per cycle sustained while the result is not stalled; a command is held in
// the command register, and its result is computed by the single pass through the
// decode and ramp logic and held in the result register.
// rst is synchronous, active high: clears both stage valids and the dimmer state
// and restores the register defaults.
// A stalled result holds; the command register keeps accepting as long as it
// can drain into the result register, so both stages stay full under a stall.
module led_fade_dimmer (
  input  logic                         clk,
  input  logic                         rst,
  ldim_cmd_if.sink                     cmd,
  ldim_res_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ldim_pkg::ADDR_W-1:0]  paddr,
  input  logic [ldim_pkg::DATA_W-1:0]  pwdata,
  output logic [ldim_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ldim_pkg::*;

  cfg_t               cfg;
  result_t            core_result;
  result_t            res_data;

  // Command stage
  logic               s_valid;
  logic [CMD_W-1:0]   s_command;
  logic [LEVEL_W-1:0] s_value;

  // Result stage
  logic               res_valid;
  logic               out_free;
  logic               s_adv;

  assign pready = 1'b1;

  ldim_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Result register is free when empty or being drained this cycle.
  assign out_free  = !res_valid || res.ready;
  assign s_adv     = s_valid && out_free;
  assign cmd.ready = !s_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.ready) s_valid   <= cmd.valid;
      if (out_free)  res_valid <= s_valid;
    end
  end

  // Capture the command payload on transfer.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s_command <= cmd.command;
      s_value   <= cmd.value;
    end
  end

  // State advances exactly when the staged command moves into the result register.
  ldim_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (s_adv),
    .command (s_command),
    .value   (s_value),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (s_adv) res_data <= core_result;
  end

  assign res.valid     = res_valid;
  assign res.pwm_level = res_data.pwm_level;
  assign res.ramping   = res_data.ramping;
  assign res.lit       = res_data.lit;
  assign res.on_state  = res_data.on_state;

endmodule

FILE: rtl/core/ldim_checker.sv
// Port-level checks for the LED fade dimmer, bound to the top level.
module ldim_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pwm_level,
  input logic       ramping,
  input logic       lit,
  input logic       on_state
);
  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] pending;
  logic [7:0] last_level;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_level <= '0;
    end else begin
      pending <= pending + {2'b0, in_xfer} - {2'b0, out_xfer};
      if (out_xfer) last_level <= pwm_level;
    end
  end

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pwm_level) && $stable(ramping)
      && $stable(lit) && $stable(on_state))
    else $error("result changed while stalled");

  // No result without an outstanding command.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending command");

  // At most two commands in flight.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("too many commands in flight");

  // Level settled at the target cannot move, and while settled lit needs the on state.
  a_settled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ramping |-> pwm_level == last_level && (!lit || on_state))
    else $error("settled level moved or lit while off");

endmodule

bind led_fade_dimmer ldim_checker u_ldim_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .pwm_level (res.pwm_level),
  .ramping   (res.ramping),
  .lit       (res.lit),
  .on_state  (res.on_state)
);
